/* rtl/dqs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dqs_pkg;

	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [2:0] KIND_POP_BACK   = 3'd3;
	localparam logic [2:0] KIND_SEARCH     = 3'd4;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] popped_value;
		logic [4:0]         position;
		logic [4:0]         fill_count;
	} rsp_t;

	// broadcast to every cell of the ring
	typedef struct packed {
		logic shift_prev;
		logic shift_next;
		logic load_head;
		logic load_slot;
	} cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/deque_with_search_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of signed 32-bit values held in a ring of CAPACITY cells,
// front entry always in cell 0. Push front, push back and pop front load their result
// when accepted; pop back and search first rotate the whole ring once past the single
// comparator at cell 0, and the input is stalled until their result is loaded. A push
// to a full queue is dropped with status full; a pop or search of an empty queue
// reports status empty; a search with no match reports not found. The result sits in
// an output register; a new request may be accepted in the cycle the previous result
// is taken, while a stalled result holds off the input.
// Cell contents have no reset; only entries inside the held range are ever reported.
module deque_with_search_core import dqs_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        req_valid,
	output logic       req_stall,
	input  wire req_t  req,
	output logic       rsp_valid,
	input  wire        rsp_stall,
	output rsp_t       rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_HOLD = 2'd2;

	function automatic logic [4:0] to5(input logic [CNT_W-1:0] x);
		logic [CNT_W+4:0] w;
		w = {5'd0, x};
		return w[4:0];
	endfunction

	logic [1:0]         state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [IDX_W-1:0]   step_q, step_d;
	logic               search_q, search_d;
	logic signed [31:0] key_q, key_d;
	logic               found_q, found_d;
	logic [CNT_W-1:0]   pos_q, pos_d;
	logic signed [31:0] popped_q, popped_d;
	logic               rsp_valid_q;
	rsp_t               rsp_q, rsp_d;
	logic               rsp_load;

	cell_ctrl_t         ctrl;
	logic signed [31:0] cell_data [CAPACITY];
	logic signed [31:0] head;

	logic rsp_free, accept, empty, full;
	logic [CNT_W-1:0] step_ext;
	logic in_range, match, last_step;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			localparam int PREV = (gi + CAPACITY - 1) % CAPACITY;
			localparam int NEXT = (gi + 1) % CAPACITY;
			dqs_cell #(
				.INDEX(gi),
				.CNT_W(CNT_W)
			) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.value    (req.value),
				.slot     (count_q),
				.prev_data(cell_data[PREV]),
				.next_data(cell_data[NEXT]),
				.data     (cell_data[gi])
			);
		end
	endgenerate

	assign head      = cell_data[0];
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || !rsp_free;
	assign accept    = req_valid && !req_stall;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(CAPACITY));

	assign step_ext  = CNT_W'(step_q);
	assign in_range  = (step_ext < count_q);
	assign match     = in_range && !found_q && (head == key_q);
	assign last_step = (step_q == IDX_W'(CAPACITY - 1));

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		step_d   = step_q;
		search_d = search_q;
		key_d    = key_q;
		found_d  = found_q;
		pos_d    = pos_q;
		popped_d = popped_q;
		ctrl     = '0;
		rsp_load = 1'b0;
		rsp_d    = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					rsp_load = 1'b1;
					rsp_d.status = STATUS_OK;
					unique case (req.kind)
						KIND_PUSH_FRONT: begin
							if (full) begin
								rsp_d.status = STATUS_FULL;
							end else begin
								ctrl.shift_prev = 1'b1;
								ctrl.load_head  = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
						KIND_PUSH_BACK: begin
							if (full) begin
								rsp_d.status = STATUS_FULL;
							end else begin
								ctrl.load_slot = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
						KIND_POP_FRONT: begin
							if (empty) begin
								rsp_d.status = STATUS_EMPTY;
							end else begin
								rsp_d.popped_value = head;
								ctrl.shift_next = 1'b1;
								count_d = count_q - 1'b1;
							end
						end
						KIND_POP_BACK, KIND_SEARCH: begin
							if (empty) begin
								rsp_d.status = STATUS_EMPTY;
							end else begin
								// result comes after one full turn of the ring
								rsp_load = 1'b0;
								state_d  = S_WALK;
								step_d   = '0;
								search_d = (req.kind == KIND_SEARCH);
								key_d    = req.value;
								found_d  = 1'b0;
								pos_d    = '0;
								popped_d = '0;
							end
						end
						default: begin
						end
					endcase
					rsp_d.fill_count = to5(count_d);
				end
			end
			S_WALK: begin
				ctrl.shift_next = 1'b1;
				step_d = step_q + 1'b1;
				if (match) begin
					found_d = 1'b1;
					pos_d   = step_ext + 1'b1;
				end
				if (!search_q && (step_ext == count_q - 1'b1)) begin
					popped_d = head;
				end
				if (last_step) begin
					step_d = '0;
					if (!search_q) begin
						count_d = count_q - 1'b1;
					end
					state_d = S_HOLD;
					if (rsp_free) begin
						rsp_load = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			S_HOLD: begin
				if (rsp_free) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (state_q != S_IDLE) begin
			if (search_q) begin
				rsp_d.status   = found_d ? STATUS_OK : STATUS_NOTFOUND;
				rsp_d.position = to5(pos_d);
			end else begin
				rsp_d.status       = STATUS_OK;
				rsp_d.popped_value = popped_d;
			end
			rsp_d.fill_count = to5(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			search_q    <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			step_q   <= step_d;
			search_q <= search_d;
			found_q  <= found_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q    <= key_d;
		pos_q    <= pos_d;
		popped_q <= popped_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

/* rtl/dqs_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module dqs_cell import dqs_pkg::*; #(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  wire                     clk,
	input  wire cell_ctrl_t         ctrl,
	input  wire logic signed [31:0] value,
	input  wire logic [CNT_W-1:0]   slot,
	input  wire logic signed [31:0] prev_data,
	input  wire logic signed [31:0] next_data,
	output logic signed [31:0]      data
);

	localparam bit HEAD = (INDEX == 0);

	logic signed [31:0] data_q;

	always_ff @(posedge clk) begin
		priority if (ctrl.shift_next) begin
			data_q <= next_data;
		end else if (ctrl.shift_prev) begin
			// push front: the head takes the new value, the rest move back one
			data_q <= (HEAD && ctrl.load_head) ? value : prev_data;
		end else if (ctrl.load_slot && (slot == CNT_W'(INDEX))) begin
			data_q <= value;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire
